/* rtl/eimw_pkg.sv */
// shared types, constants and a helper function for the motor speed bus writer
package eimw_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_GROUP_ADDRESS = 3'd1,
    REG_FRONT_ADDRESS = 3'd2,
    REG_REAR_ADDRESS  = 3'd3,
    REG_LEFT_ADDRESS  = 3'd4,
    REG_RIGHT_ADDRESS = 3'd5,
    REG_HOLD_TICKS    = 3'd6
  } cfg_reg_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;

  // register reset values
  localparam logic       MODE_RST          = 1'b0;
  localparam logic [7:0] GROUP_ADDRESS_RST = 8'h10;
  localparam logic [7:0] FRONT_ADDRESS_RST = 8'h52;
  localparam logic [7:0] REAR_ADDRESS_RST  = 8'h54;
  localparam logic [7:0] LEFT_ADDRESS_RST  = 8'h58;
  localparam logic [7:0] RIGHT_ADDRESS_RST = 8'h56;
  localparam logic [7:0] HOLD_TICKS_RST    = 8'd2;

  // acknowledge flag bits
  localparam logic [4:0] FLAG_FRONT = 5'h01;
  localparam logic [4:0] FLAG_LEFT  = 5'h02;
  localparam logic [4:0] FLAG_RIGHT = 5'h04;
  localparam logic [4:0] FLAG_REAR  = 5'h08;
  localparam logic [4:0] FLAG_GROUP = 5'h10;

  // configuration as seen by the bus engine
  typedef struct packed {
    logic       mode;
    logic [7:0] group_address;
    logic [7:0] front_address;
    logic [7:0] rear_address;
    logic [7:0] left_address;
    logic [7:0] right_address;
    logic [7:0] hold_ticks;
  } cfg_t;

  // one tick of input
  typedef struct packed {
    logic       frame_request;
    logic [7:0] front_speed;
    logic [7:0] rear_speed;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       clock_line;
    logic       data_line;
  } in_item_t;

  // one tick of result
  typedef struct packed {
    logic       clock_pull_low;
    logic       data_pull_low;
    logic       busy_res;
    logic       frame_done;
    logic [4:0] ack_flags;
  } out_item_t;

  // flag bit for a controller in front, rear, left, right order
  function automatic logic [4:0] target_flag(input logic [1:0] idx);
    logic [4:0] flag;
    unique case (idx)
      2'd0:    flag = FLAG_FRONT;
      2'd1:    flag = FLAG_REAR;
      2'd2:    flag = FLAG_LEFT;
      default: flag = FLAG_RIGHT;
    endcase
    return flag;
  endfunction

endpackage

/* rtl/eimw_cfg_regs.sv */
// configuration register file of the motor speed bus writer
module eimw_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [eimw_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [eimw_pkg::CfgDataWidth-1:0]     cfg_wdata,
  output eimw_pkg::cfg_t                        cfg
);

  eimw_pkg::cfg_t cfg_r;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= eimw_pkg::MODE_RST;
      cfg_r.group_address <= eimw_pkg::GROUP_ADDRESS_RST;
      cfg_r.front_address <= eimw_pkg::FRONT_ADDRESS_RST;
      cfg_r.rear_address  <= eimw_pkg::REAR_ADDRESS_RST;
      cfg_r.left_address  <= eimw_pkg::LEFT_ADDRESS_RST;
      cfg_r.right_address <= eimw_pkg::RIGHT_ADDRESS_RST;
      cfg_r.hold_ticks    <= eimw_pkg::HOLD_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eimw_pkg::REG_MODE:          cfg_r.mode          <= cfg_wdata[0];
        eimw_pkg::REG_GROUP_ADDRESS: cfg_r.group_address <= cfg_wdata;
        eimw_pkg::REG_FRONT_ADDRESS: cfg_r.front_address <= cfg_wdata;
        eimw_pkg::REG_REAR_ADDRESS:  cfg_r.rear_address  <= cfg_wdata;
        eimw_pkg::REG_LEFT_ADDRESS:  cfg_r.left_address  <= cfg_wdata;
        eimw_pkg::REG_RIGHT_ADDRESS: cfg_r.right_address <= cfg_wdata;
        eimw_pkg::REG_HOLD_TICKS:    cfg_r.hold_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/eimw_in_stage.sv */
// input holding register in front of the bus engine
module eimw_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eimw_pkg::in_item_t  in_data,
  output logic                item_valid,
  input  logic                item_ready,
  output eimw_pkg::in_item_t  item_data
);

  logic               hold_valid_r;
  logic               hold_valid_nxt;
  eimw_pkg::in_item_t hold_data_r;
  logic               take;

  // refill whenever empty or draining this cycle
  assign in_ready = !hold_valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
    end else if (item_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    if (take) begin
      hold_data_r <= in_data;
    end
  end

  assign item_valid = hold_valid_r;
  assign item_data  = hold_data_r;

endmodule

/* rtl/eimw_engine.sv */
// bus state machine with speed store and result register
module eimw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  eimw_pkg::cfg_t      cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  eimw_pkg::in_item_t  item_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eimw_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_REL, PH_S_WAIT, PH_S_HIGH, PH_S_LOW,
    PH_B_DRIVE, PH_B_WAIT, PH_B_HOLD,
    PH_A_REL, PH_A_WAIT, PH_A_HOLD, PH_A_AFTER,
    PH_P_LOW, PH_P_WAIT, PH_P_HOLD, PH_P_END
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          bit_count_r, bit_count_nxt;
  logic [2:0]          byte_index_r, byte_index_nxt;
  logic [1:0]          target_index_r, target_index_nxt;
  logic [7:0]          delay_count_r, delay_count_nxt;
  logic [7:0]          shift_byte_r, shift_byte_nxt;
  logic [4:0]          flag_bits_r, flag_bits_nxt;
  logic                address_acked_r, address_acked_nxt;
  logic                scl_low_r, scl_low_nxt;
  logic                sda_low_r, sda_low_nxt;
  logic [7:0]          speed_store_r [4];
  logic                store_we;
  logic                done_nxt;
  logic                out_valid_r;
  eimw_pkg::out_item_t out_data_r;
  logic                fire;

  logic [7:0] cnt_inc;
  logic [7:0] hold_eff;
  logic       over;
  logic [7:0] cnt_after;
  logic [3:0] bit_inc;
  logic [7:0] addr_sel;
  logic [1:0] rd_idx;
  logic [7:0] rd_speed;

  // a tick steps when the result register is free or being emptied
  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;

  // delay phase counter, zero hold counts as one tick
  assign cnt_inc   = delay_count_r + 8'd1;
  assign hold_eff  = (cfg.hold_ticks == 8'd0) ? 8'd1 : cfg.hold_ticks;
  assign over      = (cnt_inc >= hold_eff);
  assign cnt_after = over ? 8'd0 : cnt_inc;
  assign bit_inc   = bit_count_r + 4'd1;

  // per-controller address pick
  always_comb begin
    unique case (target_index_r)
      2'd0:    addr_sel = cfg.front_address;
      2'd1:    addr_sel = cfg.rear_address;
      2'd2:    addr_sel = cfg.left_address;
      default: addr_sel = cfg.right_address;
    endcase
  end

  // speed byte for the next data byte
  assign rd_idx   = (byte_index_r == 3'd0) ? (cfg.mode ? target_index_r : 2'd0)
                                           : byte_index_r[1:0];
  assign rd_speed = speed_store_r[rd_idx];

  // next state for one tick
  always_comb begin
    phase_nxt         = phase_r;
    bit_count_nxt     = bit_count_r;
    byte_index_nxt    = byte_index_r;
    target_index_nxt  = target_index_r;
    delay_count_nxt   = delay_count_r;
    shift_byte_nxt    = shift_byte_r;
    flag_bits_nxt     = flag_bits_r;
    address_acked_nxt = address_acked_r;
    scl_low_nxt       = scl_low_r;
    sda_low_nxt       = sda_low_r;
    store_we          = 1'b0;
    done_nxt          = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        scl_low_nxt = 1'b0;
        sda_low_nxt = 1'b0;
        if (item_data.frame_request) begin
          store_we          = 1'b1;
          flag_bits_nxt     = 5'd0;
          target_index_nxt  = 2'd0;
          byte_index_nxt    = 3'd0;
          address_acked_nxt = 1'b0;
          delay_count_nxt   = 8'd0;
          phase_nxt         = PH_S_REL;
        end
      end
      PH_S_REL: begin
        sda_low_nxt     = 1'b0;
        delay_count_nxt = cnt_after;
        if (over) phase_nxt = PH_S_WAIT;
      end
      PH_S_WAIT: begin
        scl_low_nxt = 1'b0;
        if (item_data.clock_line) phase_nxt = PH_S_HIGH;
      end
      PH_S_HIGH: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          sda_low_nxt = 1'b1;
          phase_nxt   = PH_S_LOW;
        end
      end
      PH_S_LOW: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          scl_low_nxt    = 1'b1;
          byte_index_nxt = 3'd0;
          shift_byte_nxt = cfg.mode ? addr_sel : cfg.group_address;
          bit_count_nxt  = 4'd0;
          phase_nxt      = PH_B_DRIVE;
        end
      end
      PH_B_DRIVE: begin
        sda_low_nxt = !shift_byte_r[7];
        phase_nxt   = PH_B_WAIT;
      end
      PH_B_WAIT: begin
        scl_low_nxt = 1'b0;
        if (item_data.clock_line) phase_nxt = PH_B_HOLD;
      end
      PH_B_HOLD: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          scl_low_nxt    = 1'b1;
          shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
          bit_count_nxt  = bit_inc;
          if (bit_inc >= 4'd8) begin
            sda_low_nxt = 1'b0;
            phase_nxt   = PH_A_REL;
          end else begin
            phase_nxt = PH_B_DRIVE;
          end
        end
      end
      PH_A_REL: begin
        sda_low_nxt     = 1'b0;
        delay_count_nxt = cnt_after;
        if (over) phase_nxt = PH_A_WAIT;
      end
      PH_A_WAIT: begin
        scl_low_nxt = 1'b0;
        if (item_data.clock_line) phase_nxt = PH_A_HOLD;
      end
      PH_A_HOLD: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          if (byte_index_r == 3'd0) address_acked_nxt = !item_data.data_line;
          scl_low_nxt = 1'b1;
          phase_nxt   = PH_A_AFTER;
        end
      end
      PH_A_AFTER: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          if (byte_index_r == 3'd0) begin
            // address byte done: data follows only on acknowledge
            if (!address_acked_r) begin
              phase_nxt = PH_P_LOW;
            end else begin
              byte_index_nxt = 3'd1;
              shift_byte_nxt = rd_speed;
              bit_count_nxt  = 4'd0;
              phase_nxt      = PH_B_DRIVE;
            end
          end else if (!cfg.mode) begin
            if (byte_index_r < 3'd4) begin
              byte_index_nxt = byte_index_r + 3'd1;
              shift_byte_nxt = rd_speed;
              bit_count_nxt  = 4'd0;
              phase_nxt      = PH_B_DRIVE;
            end else begin
              flag_bits_nxt = flag_bits_r | eimw_pkg::FLAG_GROUP;
              phase_nxt     = PH_P_LOW;
            end
          end else begin
            flag_bits_nxt = flag_bits_r | eimw_pkg::target_flag(target_index_r);
            phase_nxt     = PH_P_LOW;
          end
        end
      end
      PH_P_LOW: begin
        sda_low_nxt     = 1'b1;
        delay_count_nxt = cnt_after;
        if (over) phase_nxt = PH_P_WAIT;
      end
      PH_P_WAIT: begin
        scl_low_nxt = 1'b0;
        if (item_data.clock_line) phase_nxt = PH_P_HOLD;
      end
      PH_P_HOLD: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          sda_low_nxt = 1'b0;
          phase_nxt   = PH_P_END;
        end
      end
      PH_P_END: begin
        delay_count_nxt = cnt_after;
        if (over) begin
          // next controller or end of frame
          if (cfg.mode && (target_index_r < 2'd3)) begin
            target_index_nxt  = target_index_r + 2'd1;
            byte_index_nxt    = 3'd0;
            address_acked_nxt = 1'b0;
            phase_nxt         = PH_S_REL;
          end else begin
            done_nxt         = 1'b1;
            target_index_nxt = 2'd0;
            byte_index_nxt   = 3'd0;
            phase_nxt        = PH_IDLE;
          end
        end
      end
    endcase
  end

  // state, speed store and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      bit_count_r     <= 4'd0;
      byte_index_r    <= 3'd0;
      target_index_r  <= 2'd0;
      delay_count_r   <= 8'd0;
      shift_byte_r    <= 8'd0;
      flag_bits_r     <= 5'd0;
      address_acked_r <= 1'b0;
      scl_low_r       <= 1'b0;
      sda_low_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (fire) begin
        phase_r         <= phase_nxt;
        bit_count_r     <= bit_count_nxt;
        byte_index_r    <= byte_index_nxt;
        target_index_r  <= target_index_nxt;
        delay_count_r   <= delay_count_nxt;
        shift_byte_r    <= shift_byte_nxt;
        flag_bits_r     <= flag_bits_nxt;
        address_acked_r <= address_acked_nxt;
        scl_low_r       <= scl_low_nxt;
        sda_low_r       <= sda_low_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      out_data_r.clock_pull_low <= scl_low_nxt;
      out_data_r.data_pull_low  <= sda_low_nxt;
      out_data_r.busy_res       <= (phase_nxt != PH_IDLE);
      out_data_r.frame_done     <= done_nxt;
      out_data_r.ack_flags      <= flag_bits_nxt;
    end
    if (fire && store_we) begin
      speed_store_r[0] <= item_data.front_speed;
      speed_store_r[1] <= item_data.rear_speed;
      speed_store_r[2] <= item_data.left_speed;
      speed_store_r[3] <= item_data.right_speed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // completion tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_done) |-> !out_data_r.busy_res)
    else $error("frame_done with busy_res set");

  // delay counter is cleared whenever the engine sits idle
  a_idle_delay_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (delay_count_r == 8'd0))
    else $error("delay counter not cleared in idle");

  // bit counter never passes a full byte
  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit counter out of range");

  // a new frame starts with cleared flags
  a_frame_start_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (phase_r == PH_IDLE) && item_data.frame_request)
      |=> ((flag_bits_r == 5'd0) && (phase_r == PH_S_REL)))
    else $error("frame start did not clear flags");

  // idle tick without request stays idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (phase_r == PH_IDLE) && !item_data.frame_request)
      |=> (phase_r == PH_IDLE))
    else $error("left idle without a request");
`endif

endmodule

/* rtl/esc_i2c_motor_writer.sv */
// top level of the motor speed bus writer
// a transaction passes the input holding register and then the result register
// throughput: one transaction per cycle while neither side stalls,
// with one result per transaction
// the input holding register and the result register are each one entry deep,
// so either side may stall without losing a tick
// reset: synchronous active-low rst_n clears control state, restores register
// defaults and releases both bus lines; the speed store is loaded at frame start
module esc_i2c_motor_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  eimw_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output eimw_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [eimw_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [eimw_pkg::CfgDataWidth-1:0]  cfg_wdata
);

  eimw_pkg::cfg_t     cfg;
  logic               item_valid;
  logic               item_ready;
  eimw_pkg::in_item_t item_data;

  // configuration registers
  eimw_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  eimw_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data)
  );

  // bus engine and result register
  eimw_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the motor speed bus writer, one transaction per bus tick
module testbench;

  // bus sequencer phases as tracked by the checker
  typedef enum logic [4:0] {
    BUS_IDLE, START_RELEASE, START_WAIT, START_HIGH, START_LOW,
    BIT_DRIVE, BIT_WAIT, BIT_HOLD,
    ACK_RELEASE, ACK_WAIT, ACK_HOLD, ACK_AFTER,
    STOP_LOW, STOP_WAIT, STOP_HOLD, STOP_END
  } bus_phase_t;

  // tracks the bus sequencer tick by tick and holds the line levels still to come
  class motor_bus_checker;
    eimw_pkg::cfg_t      regs;
    bus_phase_t          ph;
    logic [3:0]          bit_cnt;
    logic [2:0]          byte_idx;
    logic [1:0]          target;
    logic [7:0]          hold_cnt;
    logic [7:0]          shifter;
    logic [7:0]          speeds [4];
    logic [4:0]          flags;
    logic                addr_acked;
    logic                scl_low;
    logic                sda_low;
    eimw_pkg::out_item_t levels_due [$];
    int                  mismatches;

    function new();
      regs = '{eimw_pkg::MODE_RST, eimw_pkg::GROUP_ADDRESS_RST,
               eimw_pkg::FRONT_ADDRESS_RST, eimw_pkg::REAR_ADDRESS_RST,
               eimw_pkg::LEFT_ADDRESS_RST, eimw_pkg::RIGHT_ADDRESS_RST,
               eimw_pkg::HOLD_TICKS_RST};
      ph = BUS_IDLE;
      bit_cnt = '0;
      byte_idx = '0;
      target = '0;
      hold_cnt = '0;
      shifter = '0;
      foreach (speeds[i]) speeds[i] = '0;
      flags = '0;
      addr_acked = 1'b0;
      scl_low = 1'b0;
      sda_low = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(eimw_pkg::cfg_reg_t idx, logic [7:0] v);
      case (idx)
        eimw_pkg::REG_MODE:          regs.mode = v[0];
        eimw_pkg::REG_GROUP_ADDRESS: regs.group_address = v;
        eimw_pkg::REG_FRONT_ADDRESS: regs.front_address = v;
        eimw_pkg::REG_REAR_ADDRESS:  regs.rear_address = v;
        eimw_pkg::REG_LEFT_ADDRESS:  regs.left_address = v;
        eimw_pkg::REG_RIGHT_ADDRESS: regs.right_address = v;
        eimw_pkg::REG_HOLD_TICKS:    regs.hold_ticks = v;
        default: ;
      endcase
    endfunction

    // one tick of a delay phase, zero hold counts as one
    function bit hold_elapsed();
      logic [7:0] limit;
      limit = (regs.hold_ticks == 8'd0) ? 8'd1 : regs.hold_ticks;
      hold_cnt = hold_cnt + 8'd1;
      if (hold_cnt >= limit) begin
        hold_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [7:0] controller_address();
      case (target)
        2'd0:    return regs.front_address;
        2'd1:    return regs.rear_address;
        2'd2:    return regs.left_address;
        default: return regs.right_address;
      endcase
    endfunction

    // controllers are visited front, rear, left, right
    function logic [4:0] controller_flag();
      case (target)
        2'd0:    return eimw_pkg::FLAG_FRONT;
        2'd1:    return eimw_pkg::FLAG_REAR;
        2'd2:    return eimw_pkg::FLAG_LEFT;
        default: return eimw_pkg::FLAG_RIGHT;
      endcase
    endfunction

    function void load_byte(logic [7:0] b);
      shifter = b;
      bit_cnt = '0;
      ph = BIT_DRIVE;
    endfunction

    // advance one bus tick for an accepted transaction and queue its line levels
    function void take_tick(eimw_pkg::in_item_t t);
      logic [1:0]          k;
      logic                frame_end;
      eimw_pkg::out_item_t want;
      frame_end = 1'b0;
      case (ph)
        BUS_IDLE: begin
          scl_low = 1'b0;
          sda_low = 1'b0;
          if (t.frame_request) begin
            speeds[0] = t.front_speed;
            speeds[1] = t.rear_speed;
            speeds[2] = t.left_speed;
            speeds[3] = t.right_speed;
            flags = '0;
            target = '0;
            byte_idx = '0;
            addr_acked = 1'b0;
            hold_cnt = '0;
            ph = START_RELEASE;
          end
        end
        START_RELEASE: begin
          sda_low = 1'b0;
          if (hold_elapsed()) ph = START_WAIT;
        end
        START_WAIT: begin
          scl_low = 1'b0;
          if (t.clock_line) ph = START_HIGH;
        end
        START_HIGH: if (hold_elapsed()) begin
          sda_low = 1'b1;
          ph = START_LOW;
        end
        START_LOW: if (hold_elapsed()) begin
          scl_low = 1'b1;
          byte_idx = '0;
          load_byte(regs.mode ? controller_address() : regs.group_address);
        end
        BIT_DRIVE: begin
          sda_low = ~shifter[7];
          ph = BIT_WAIT;
        end
        BIT_WAIT: begin
          scl_low = 1'b0;
          if (t.clock_line) ph = BIT_HOLD;
        end
        BIT_HOLD: if (hold_elapsed()) begin
          scl_low = 1'b1;
          shifter = {shifter[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            sda_low = 1'b0;
            ph = ACK_RELEASE;
          end else begin
            ph = BIT_DRIVE;
          end
        end
        ACK_RELEASE: begin
          sda_low = 1'b0;
          if (hold_elapsed()) ph = ACK_WAIT;
        end
        ACK_WAIT: begin
          scl_low = 1'b0;
          if (t.clock_line) ph = ACK_HOLD;
        end
        // only the address acknowledge counts, low data line means acknowledged
        ACK_HOLD: if (hold_elapsed()) begin
          if (byte_idx == 3'd0) addr_acked = ~t.data_line;
          scl_low = 1'b1;
          ph = ACK_AFTER;
        end
        ACK_AFTER: if (hold_elapsed()) begin
          if (byte_idx == 3'd0) begin
            if (!addr_acked) begin
              ph = STOP_LOW;
            end else begin
              byte_idx = 3'd1;
              load_byte(regs.mode ? speeds[target] : speeds[0]);
            end
          end else if (!regs.mode) begin
            if (byte_idx < 3'd4) begin
              k = byte_idx[1:0];
              byte_idx = byte_idx + 3'd1;
              load_byte(speeds[k]);
            end else begin
              flags = flags | eimw_pkg::FLAG_GROUP;
              ph = STOP_LOW;
            end
          end else begin
            flags = flags | controller_flag();
            ph = STOP_LOW;
          end
        end
        STOP_LOW: begin
          sda_low = 1'b1;
          if (hold_elapsed()) ph = STOP_WAIT;
        end
        STOP_WAIT: begin
          scl_low = 1'b0;
          if (t.clock_line) ph = STOP_HOLD;
        end
        STOP_HOLD: if (hold_elapsed()) begin
          sda_low = 1'b0;
          ph = STOP_END;
        end
        // per-controller mode moves on to the next controller
        STOP_END: if (hold_elapsed()) begin
          if (regs.mode && target < 2'd3) begin
            target = target + 2'd1;
            byte_idx = '0;
            addr_acked = 1'b0;
            ph = START_RELEASE;
          end else begin
            frame_end = 1'b1;
            target = '0;
            byte_idx = '0;
            ph = BUS_IDLE;
          end
        end
        default: ;
      endcase
      want.clock_pull_low = scl_low;
      want.data_pull_low = sda_low;
      want.busy_res = (ph != BUS_IDLE);
      want.frame_done = frame_end;
      want.ack_flags = flags;
      levels_due.push_back(want);
    endfunction

    function void match_field(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result transaction with the oldest queued levels
    function void check_levels(eimw_pkg::out_item_t got);
      eimw_pkg::out_item_t want;
      if (levels_due.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = levels_due.pop_front();
      match_field("clock_pull_low", {4'b0, want.clock_pull_low},
                  {4'b0, got.clock_pull_low});
      match_field("data_pull_low", {4'b0, want.data_pull_low},
                  {4'b0, got.data_pull_low});
      match_field("busy_res", {4'b0, want.busy_res}, {4'b0, got.busy_res});
      match_field("frame_done", {4'b0, want.frame_done}, {4'b0, got.frame_done});
      match_field("ack_flags", want.ack_flags, got.ack_flags);
    endfunction

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  eimw_pkg::in_item_t                  in_data;
  logic                                out_valid;
  logic                                out_ready;
  eimw_pkg::out_item_t                 out_data;
  logic                                cfg_we;
  logic [eimw_pkg::CfgIndexWidth-1:0]  cfg_index;
  logic [eimw_pkg::CfgDataWidth-1:0]   cfg_wdata;

  motor_bus_checker chk;
  bit tx_steady;
  bit rx_steady;
  bit long_hold;
  int stretch_left;

  esc_i2c_motor_writer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side ready, with random stalls and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (90) @(negedge clk);
        long_hold = 1'b0;
      end
      out_ready <= rx_steady || ($urandom_range(0, 99) >= 20);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) chk.check_levels(out_data);
  end

  function automatic eimw_pkg::in_item_t make_tick(logic req, logic [7:0] fs,
                                                   logic [7:0] rs, logic [7:0] ls,
                                                   logic [7:0] rts,
                                                   logic cl, logic dl);
    eimw_pkg::in_item_t t;
    t.frame_request = req;
    t.front_speed = fs;
    t.rear_speed = rs;
    t.left_speed = ls;
    t.right_speed = rts;
    t.clock_line = cl;
    t.data_line = dl;
    return t;
  endfunction

  // offer one input transaction, with random idle cycles ahead of it
  task automatic send_tick(input eimw_pkg::in_item_t t);
    while (!tx_steady && $urandom_range(0, 99) < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    chk.take_tick(t);
  endtask

  task automatic write_reg(input eimw_pkg::cfg_reg_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    chk.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // bus ticks mostly with the clock released and the address acknowledged,
  // now and then a slave stretching the clock for a while
  task automatic run_random(input int count);
    eimw_pkg::in_item_t t;
    for (int i = 0; i < count; i++) begin
      t.frame_request = ($urandom_range(0, 3) != 0);
      t.front_speed = 8'($urandom_range(0, 255));
      t.rear_speed = 8'($urandom_range(0, 255));
      t.left_speed = 8'($urandom_range(0, 255));
      t.right_speed = 8'($urandom_range(0, 255));
      if (stretch_left > 0) begin
        stretch_left--;
        t.clock_line = 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 2) stretch_left = int'($urandom_range(4, 40));
        t.clock_line = ($urandom_range(0, 9) != 0);
      end
      t.data_line = ($urandom_range(0, 9) < 3);
      send_tick(t);
    end
  endtask

  // stop offering and let every queued result come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    chk = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = eimw_pkg::REG_MODE;
    cfg_wdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    long_hold = 1'b0;
    stretch_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks, frame start with extreme speeds, request while busy,
    // clock held low by a slave, then released
    send_tick(make_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_tick(make_tick(1'b1, 8'hFF, 8'h00, 8'h80, 8'h01, 1'b1, 1'b1));
    send_tick(make_tick(1'b1, 8'h00, 8'hFF, 8'h7F, 8'hFE, 1'b1, 1'b0));
    for (int i = 0; i < 10; i++)
      send_tick(make_tick(1'b1, 8'h55, 8'hAA, 8'h33, 8'hCC, 1'b0, 1'b0));
    for (int i = 0; i < 10; i++)
      send_tick(make_tick(1'b0, 8'hAA, 8'h55, 8'hCC, 8'h33, 1'b1, 1'b1));
    drain();

    // group mode, widest group address, shortest hold, no idling on either side
    write_reg(eimw_pkg::REG_MODE, 8'h00);
    write_reg(eimw_pkg::REG_GROUP_ADDRESS, 8'hFF);
    write_reg(eimw_pkg::REG_HOLD_TICKS, 8'd1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(130);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain();

    // per-controller mode with extreme addresses, long result hold-off
    write_reg(eimw_pkg::REG_MODE, 8'h01);
    write_reg(eimw_pkg::REG_FRONT_ADDRESS, 8'h00);
    write_reg(eimw_pkg::REG_REAR_ADDRESS, 8'hFF);
    write_reg(eimw_pkg::REG_LEFT_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(eimw_pkg::REG_RIGHT_ADDRESS, 8'($urandom_range(0, 255)));
    long_hold = 1'b1;
    run_random(130);
    drain();

    // group mode, zero group address, zero hold
    write_reg(eimw_pkg::REG_MODE, 8'h00);
    write_reg(eimw_pkg::REG_GROUP_ADDRESS, 8'h00);
    write_reg(eimw_pkg::REG_HOLD_TICKS, 8'd0);
    run_random(120);
    drain();

    // per-controller mode, random addresses, hold of three
    write_reg(eimw_pkg::REG_MODE, 8'h01);
    write_reg(eimw_pkg::REG_FRONT_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(eimw_pkg::REG_REAR_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(eimw_pkg::REG_LEFT_ADDRESS, 8'hFF);
    write_reg(eimw_pkg::REG_RIGHT_ADDRESS, 8'h00);
    write_reg(eimw_pkg::REG_HOLD_TICKS, 8'd3);
    run_random(110);
    drain();

    // longest hold
    write_reg(eimw_pkg::REG_MODE, 8'h00);
    write_reg(eimw_pkg::REG_HOLD_TICKS, 8'd255);
    run_random(60);
    drain();

    // back to reset-like timing in per-controller mode
    write_reg(eimw_pkg::REG_MODE, 8'h01);
    write_reg(eimw_pkg::REG_GROUP_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(eimw_pkg::REG_HOLD_TICKS, 8'd2);
    run_random(100);
    drain();

    repeat (8) @(negedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
